/* rtl/core/thal_pkg.sv */
// ----------------------------------------------------------------------------
// thal_pkg - shared types and constants
// Field widths, mode and display codes, register indexes and reset values
// for the two-level thermal alarm machine.
// ----------------------------------------------------------------------------
package thal_pkg;

    // field widths
    localparam int TEMP_W  = 12;
    localparam int DELTA_W = 10;
    localparam int TIME_W  = 24;
    localparam int MODE_W  = 3;
    localparam int DISP_W  = 3;

    // APB register space
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int RIDX_W  = 2;

    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic [DELTA_W-1:0]       t_delta;
    typedef logic [TIME_W-1:0]        t_time;
    typedef logic [MODE_W-1:0]        t_mode;
    typedef logic [DISP_W-1:0]        t_disp;
    typedef logic [RIDX_W-1:0]        t_ridx;

    // machine modes
    localparam t_mode MODE_IDLE = 3'd0;
    localparam t_mode MODE_OT1  = 3'd1;
    localparam t_mode MODE_OT2  = 3'd2;
    localparam t_mode MODE_WNM  = 3'd3;
    localparam t_mode MODE_WRS  = 3'd4;

    // display requests
    localparam t_disp DISP_NONE      = 3'd0;
    localparam t_disp DISP_PREALARM  = 3'd1;
    localparam t_disp DISP_ALARM     = 3'd2;
    localparam t_disp DISP_DRONE_IN  = 3'd3;
    localparam t_disp DISP_DRONE_OUT = 3'd4;

    // register indexes (byte address 4*i)
    localparam t_ridx REG_LEVEL1   = 2'd0;
    localparam t_ridx REG_LEVEL2   = 2'd1;
    localparam t_ridx REG_PREALARM = 2'd2;
    localparam t_ridx REG_ALARM    = 2'd3;

    // register reset values
    localparam t_temp LEVEL1_RST   = 12'sd300;
    localparam t_temp LEVEL2_RST   = 12'sd330;
    localparam t_time PREALARM_RST = 24'd5000;
    localparam t_time ALARM_RST    = 24'd5000;

    // one tick as held in the input register
    typedef struct packed {
        t_temp  temperature;
        t_delta delta_ms;
        logic   button_pressed;
        logic   drone_inside;
    } t_tick;

    // configuration handed to the machine
    typedef struct packed {
        t_temp level1_threshold;
        t_temp level2_threshold;
        t_time prealarm_time_ms;
        t_time alarm_time_ms;
    } t_cfg;

endpackage

/* rtl/core/thal_if.sv */
// ----------------------------------------------------------------------------
// thal_if - tick and result channels
// Valid/ready channels for incoming ticks and outgoing alarm results.
// ----------------------------------------------------------------------------
interface thal_in_if;
    import thal_pkg::*;

    logic   valid;
    logic   ready;
    t_temp  temperature;
    t_delta delta_ms;
    logic   button_pressed;
    logic   drone_inside;

    modport source (output valid, temperature, delta_ms, button_pressed, drone_inside,
                    input ready);
    modport sink   (input valid, temperature, delta_ms, button_pressed, drone_inside,
                    output ready);
endinterface

interface thal_out_if;
    import thal_pkg::*;

    logic  valid;
    logic  ready;
    t_mode mode_now;
    logic  pre_alarm_on;
    logic  alarm_on;
    t_disp display_request;
    logic  drone_alarm_msg;
    logic  drone_clear_msg;

    modport source (output valid, mode_now, pre_alarm_on, alarm_on, display_request,
                    drone_alarm_msg, drone_clear_msg, input ready);
    modport sink   (input valid, mode_now, pre_alarm_on, alarm_on, display_request,
                    drone_alarm_msg, drone_clear_msg, output ready);
endinterface

/* rtl/core/thal_cfg.sv */
// ----------------------------------------------------------------------------
// thal_cfg - configuration registers
// APB-style register file holding the two thresholds and the two times.
// ----------------------------------------------------------------------------
module thal_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [thal_pkg::ADDR_W-1:0]   paddr,
    input  logic [thal_pkg::DATA_W-1:0]   pwdata,
    output logic [thal_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output thal_pkg::t_cfg                o_cfg
);
    import thal_pkg::*;

    t_temp r_level1;
    t_temp r_level2;
    t_time r_prealarm;
    t_time r_alarm;
    t_ridx w_idx;
    logic  w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;

    // register writes; the upper data bits are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level1   <= LEVEL1_RST;
            r_level2   <= LEVEL2_RST;
            r_prealarm <= PREALARM_RST;
            r_alarm    <= ALARM_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_LEVEL1:   r_level1   <= pwdata[TEMP_W-1:0];
                REG_LEVEL2:   r_level2   <= pwdata[TEMP_W-1:0];
                REG_PREALARM: r_prealarm <= pwdata[TIME_W-1:0];
                REG_ALARM:    r_alarm    <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // read back, thresholds sign extended
    always_comb begin
        case (w_idx)
            REG_LEVEL1:   prdata = {{(DATA_W-TEMP_W){r_level1[TEMP_W-1]}}, r_level1};
            REG_LEVEL2:   prdata = {{(DATA_W-TEMP_W){r_level2[TEMP_W-1]}}, r_level2};
            REG_PREALARM: prdata = {{(DATA_W-TIME_W){1'b0}}, r_prealarm};
            REG_ALARM:    prdata = {{(DATA_W-TIME_W){1'b0}}, r_alarm};
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.level1_threshold = r_level1;
    assign o_cfg.level2_threshold = r_level2;
    assign o_cfg.prealarm_time_ms = r_prealarm;
    assign o_cfg.alarm_time_ms    = r_alarm;

endmodule

/* rtl/core/thal_fsm.sv */
// ----------------------------------------------------------------------------
// thal_fsm - alarm mode machine and result register
// Takes one registered tick, updates mode, timers and flags in a single
// pass and loads the result register.
// ----------------------------------------------------------------------------
module thal_fsm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tick_valid,
    input  thal_pkg::t_tick i_tick,
    input  thal_pkg::t_cfg  i_cfg,
    output logic            o_tick_take,
    thal_out_if.source      o_out
);
    import thal_pkg::*;

    // machine state
    t_mode r_mode;
    t_time r_time;
    t_time r_carried;
    logic  r_first;
    logic  r_pre;
    logic  r_alarm;

    t_mode n_mode;
    t_time n_time;
    t_time n_carried;
    logic  n_first;
    logic  n_pre;
    logic  n_alarm;

    // result register
    logic  r_out_valid;
    t_mode r_out_mode;
    logic  r_out_pre;
    logic  r_out_alarm;
    t_disp r_out_disp;
    logic  r_out_msg_alarm;
    logic  r_out_msg_clear;

    t_disp n_disp;
    logic  n_msg_alarm;
    logic  n_msg_clear;

    logic [TIME_W:0] w_sum;
    logic [TIME_W:0] w_total;
    t_time           w_time;
    logic            w_below1;
    logic            w_above1;
    logic            w_below2;
    logic            w_above2;

    assign o_tick_take = i_tick_valid & (~r_out_valid | o_out.ready);

    // saturating time in mode
    assign w_sum   = {1'b0, r_time} + {{(TIME_W+1-DELTA_W){1'b0}}, i_tick.delta_ms};
    assign w_time  = w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];
    assign w_total = {1'b0, w_time} + {1'b0, r_carried};

    // signed temperature compares
    assign w_below1 = $signed(i_tick.temperature) < $signed(i_cfg.level1_threshold);
    assign w_above1 = $signed(i_tick.temperature) > $signed(i_cfg.level1_threshold);
    assign w_below2 = $signed(i_tick.temperature) < $signed(i_cfg.level2_threshold);
    assign w_above2 = $signed(i_tick.temperature) > $signed(i_cfg.level2_threshold);

    // next state; a mode change clears the timer and marks a first tick
    always_comb begin
        n_mode      = r_mode;
        n_time      = w_time;
        n_carried   = r_carried;
        n_first     = r_first;
        n_pre       = r_pre;
        n_alarm     = r_alarm;
        n_disp      = DISP_NONE;
        n_msg_alarm = 1'b0;
        n_msg_clear = 1'b0;
        case (r_mode)
            MODE_OT1: begin
                n_first = 1'b0;
                if (w_below1) begin
                    n_mode  = MODE_IDLE;
                    n_time  = '0;
                    n_first = 1'b1;
                    n_pre   = 1'b0;
                end else if (w_time > i_cfg.prealarm_time_ms) begin
                    n_mode    = MODE_WNM;
                    n_time    = '0;
                    n_first   = 1'b1;
                    n_carried = '0;
                    n_pre     = 1'b1;
                    n_disp    = DISP_PREALARM;
                end else if (w_above2) begin
                    n_carried = w_time;
                    n_mode    = MODE_OT2;
                    n_time    = '0;
                    n_first   = 1'b1;
                end
            end
            MODE_OT2: begin
                n_first = 1'b0;
                if (w_below2) begin
                    n_mode  = MODE_OT1;
                    n_time  = '0;
                    n_first = 1'b1;
                end else if (w_time > i_cfg.alarm_time_ms) begin
                    n_mode  = MODE_WRS;
                    n_time  = '0;
                    n_first = 1'b1;
                    n_pre   = 1'b0;
                    n_alarm = 1'b1;
                    n_disp  = DISP_ALARM;
                end else if (w_total > {1'b0, i_cfg.prealarm_time_ms}) begin
                    n_pre  = 1'b1;
                    n_disp = DISP_PREALARM;
                end
            end
            MODE_WNM: begin
                n_first = 1'b0;
                if (w_above2) begin
                    n_mode  = MODE_OT2;
                    n_time  = '0;
                    n_first = 1'b1;
                end else if (w_below1) begin
                    n_mode  = MODE_IDLE;
                    n_time  = '0;
                    n_first = 1'b1;
                    if (r_pre) begin
                        n_pre  = 1'b0;
                        n_disp = i_tick.drone_inside ? DISP_DRONE_IN : DISP_DRONE_OUT;
                    end
                end
            end
            MODE_WRS: begin
                if (r_first) begin
                    n_first     = 1'b0;
                    n_msg_alarm = ~i_tick.drone_inside;
                end
                if (i_tick.button_pressed) begin
                    n_alarm     = 1'b0;
                    n_msg_clear = ~i_tick.drone_inside;
                    n_mode      = MODE_IDLE;
                    n_time      = '0;
                    n_first     = 1'b1;
                end
            end
            default: begin
                // idle, and any stray code falls back to idle
                if (r_first) begin
                    n_first   = 1'b0;
                    n_carried = '0;
                end
                n_mode = MODE_IDLE;
                if (w_above1) begin
                    n_mode  = MODE_OT1;
                    n_time  = '0;
                    n_first = 1'b1;
                end
            end
        endcase
    end

    // state update on each taken tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_time    <= '0;
            r_carried <= '0;
            r_first   <= 1'b1;
            r_pre     <= 1'b0;
            r_alarm   <= 1'b0;
        end else if (o_tick_take) begin
            r_mode    <= n_mode;
            r_time    <= n_time;
            r_carried <= n_carried;
            r_first   <= n_first;
            r_pre     <= n_pre;
            r_alarm   <= n_alarm;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_tick_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_tick_take) begin
            r_out_mode      <= n_mode;
            r_out_pre       <= n_pre;
            r_out_alarm     <= n_alarm;
            r_out_disp      <= n_disp;
            r_out_msg_alarm <= n_msg_alarm;
            r_out_msg_clear <= n_msg_clear;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.mode_now        = r_out_mode;
    assign o_out.pre_alarm_on    = r_out_pre;
    assign o_out.alarm_on        = r_out_alarm;
    assign o_out.display_request = r_out_disp;
    assign o_out.drone_alarm_msg = r_out_msg_alarm;
    assign o_out.drone_clear_msg = r_out_msg_clear;

endmodule

/* rtl/core/two_level_thermal_alarm_fsm_top.sv */
// ----------------------------------------------------------------------------
// two_level_thermal_alarm_fsm_top - two-level over-temperature alarm
// Input register, APB configuration registers and the alarm mode machine.
//
//   Port group   Dir   Handshake      Carries
//   i_in         in    valid/ready    temperature, delta_ms, button, drone
//   o_out        out   valid/ready    mode, pre-alarm, alarm, display, msgs
//   psel...      in    APB write/read thresholds and times
//
// A tick goes through the input register and single-pass mode update into
// the result register; one request is taken every cycle while the result
// channel is not stalled. A stalled result holds its register while the
// input register still takes one more request. Reset is synchronous, active
// low, and puts the machine in idle with the default thresholds and times.
// ----------------------------------------------------------------------------
module two_level_thermal_alarm_fsm_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    thal_in_if.sink                       i_in,
    thal_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [thal_pkg::ADDR_W-1:0]   paddr,
    input  logic [thal_pkg::DATA_W-1:0]   pwdata,
    output logic [thal_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import thal_pkg::*;

    logic  r_in_valid;
    t_tick r_in;
    logic  w_take;
    t_cfg  w_cfg;

    assign i_in.ready = ~r_in_valid | w_take;

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.temperature    <= i_in.temperature;
            r_in.delta_ms       <= i_in.delta_ms;
            r_in.button_pressed <= i_in.button_pressed;
            r_in.drone_inside   <= i_in.drone_inside;
        end
    end

    thal_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    thal_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_valid (r_in_valid),
        .i_tick       (r_in),
        .i_cfg        (w_cfg),
        .o_tick_take  (w_take),
        .o_out        (o_out)
    );

endmodule

/* bench/thal_alarm_checker.sv */
// ----------------------------------------------------------------------------
// thal_alarm_checker - result scoreboard for the two-level thermal alarm
// Watches the tick channel, the result channel and the APB register writes.
// It keeps its own copy of the alarm machine and its thresholds, works out
// the outcome of every accepted tick request and compares each accepted
// result request field by field with the oldest outcome still due.
// ----------------------------------------------------------------------------
module thal_alarm_checker
    import thal_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    thal_in_if                i_tick,
    thal_out_if               i_res,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output int                o_fail_cnt,
    output int                o_pending,
    output int                o_result_cnt
);

    // only the first mismatches are printed, the rest are just counted
    localparam int REPORT_MAX = 64;

    typedef struct packed {
        t_mode mode_now;
        logic  pre_alarm_on;
        logic  alarm_on;
        t_disp display_request;
        logic  drone_alarm_msg;
        logic  drone_clear_msg;
    } t_alarm_out;

    // own copy of the thresholds and of the machine state
    t_cfg  cfg;
    t_mode mode_q;
    t_time time_in_mode;
    t_time carried_time;
    logic  first_tick;
    logic  pre_alarm;
    logic  alarm;

    t_alarm_out alarm_outs_due[$];
    int         fails = 0;
    int         results_seen = 0;

    function automatic void enter_mode(input t_mode m);
        mode_q       = m;
        time_in_mode = '0;
        first_tick   = 1'b1;
    endfunction

    // one tick of the alarm machine
    function automatic t_alarm_out step_alarm_fsm(input t_tick tk);
        logic [TIME_W:0] sum;
        t_temp           temp;
        t_temp           l1;
        t_temp           l2;
        t_alarm_out      o;
        o    = '0;
        temp = tk.temperature;
        l1   = cfg.level1_threshold;
        l2   = cfg.level2_threshold;

        // saturating time in mode
        sum          = {1'b0, time_in_mode} + {{(TIME_W+1-DELTA_W){1'b0}}, tk.delta_ms};
        time_in_mode = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

        case (mode_q)
            MODE_OT1: begin
                first_tick = 1'b0;
                if (temp < l1) begin
                    enter_mode(MODE_IDLE);
                    pre_alarm = 1'b0;
                end else if (time_in_mode > cfg.prealarm_time_ms) begin
                    enter_mode(MODE_WNM);
                    carried_time      = '0;
                    pre_alarm         = 1'b1;
                    o.display_request = DISP_PREALARM;
                end else if (temp > l2) begin
                    carried_time = time_in_mode;
                    enter_mode(MODE_OT2);
                end
            end
            MODE_OT2: begin
                first_tick = 1'b0;
                if (temp < l2) begin
                    // carried time is kept on the way down
                    enter_mode(MODE_OT1);
                end else if (time_in_mode > cfg.alarm_time_ms) begin
                    enter_mode(MODE_WRS);
                    pre_alarm         = 1'b0;
                    alarm             = 1'b1;
                    o.display_request = DISP_ALARM;
                end else if (({1'b0, time_in_mode} + {1'b0, carried_time}) >
                             {1'b0, cfg.prealarm_time_ms}) begin
                    pre_alarm         = 1'b1;
                    o.display_request = DISP_PREALARM;
                end
            end
            MODE_WNM: begin
                first_tick = 1'b0;
                if (temp > l2) begin
                    enter_mode(MODE_OT2);
                end else if (temp < l1) begin
                    enter_mode(MODE_IDLE);
                    if (pre_alarm) begin
                        pre_alarm         = 1'b0;
                        o.display_request = tk.drone_inside ? DISP_DRONE_IN : DISP_DRONE_OUT;
                    end
                end
            end
            MODE_WRS: begin
                // alarm and clear can both go out on the first tick
                if (first_tick) begin
                    first_tick        = 1'b0;
                    o.drone_alarm_msg = !tk.drone_inside;
                end
                if (tk.button_pressed) begin
                    alarm             = 1'b0;
                    o.drone_clear_msg = !tk.drone_inside;
                    enter_mode(MODE_IDLE);
                end
            end
            default: begin
                if (first_tick) begin
                    first_tick   = 1'b0;
                    carried_time = '0;
                end
                mode_q = MODE_IDLE;
                if (temp > l1)
                    enter_mode(MODE_OT1);
            end
        endcase

        o.mode_now     = mode_q;
        o.pre_alarm_on = pre_alarm;
        o.alarm_on     = alarm;
        return o;
    endfunction

    function automatic void take_reg_write(input logic [ADDR_W-1:0] addr,
                                           input logic [DATA_W-1:0] data);
        case (t_ridx'(addr >> 2))
            REG_LEVEL1:   cfg.level1_threshold = data[TEMP_W-1:0];
            REG_LEVEL2:   cfg.level2_threshold = data[TEMP_W-1:0];
            REG_PREALARM: cfg.prealarm_time_ms = data[TIME_W-1:0];
            REG_ALARM:    cfg.alarm_time_ms    = data[TIME_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [2:0] want,
                                        input logic [2:0] got);
        if (got !== want) begin
            fails++;
            if (fails <= REPORT_MAX)
                $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    // sample both channels and the register port on every rising edge
    always @(posedge i_clk) begin : watch
        t_tick      tk;
        t_alarm_out want;
        if (!i_rst_n) begin
            cfg          = '{LEVEL1_RST, LEVEL2_RST, PREALARM_RST, ALARM_RST};
            mode_q       = MODE_IDLE;
            time_in_mode = '0;
            carried_time = '0;
            first_tick   = 1'b1;
            pre_alarm    = 1'b0;
            alarm        = 1'b0;
            alarm_outs_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                take_reg_write(i_paddr, i_pwdata);

            if (i_tick.valid && i_tick.ready) begin
                tk.temperature    = i_tick.temperature;
                tk.delta_ms       = i_tick.delta_ms;
                tk.button_pressed = i_tick.button_pressed;
                tk.drone_inside   = i_tick.drone_inside;
                alarm_outs_due.push_back(step_alarm_fsm(tk));
            end

            if (i_res.valid && i_res.ready) begin
                results_seen++;
                if (alarm_outs_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $error("result request with no tick outstanding");
                end else begin
                    want = alarm_outs_due.pop_front();
                    check_field("mode_now", want.mode_now, i_res.mode_now);
                    check_field("pre_alarm_on", 3'(want.pre_alarm_on),
                                3'(i_res.pre_alarm_on));
                    check_field("alarm_on", 3'(want.alarm_on), 3'(i_res.alarm_on));
                    check_field("display_request", want.display_request,
                                i_res.display_request);
                    check_field("drone_alarm_msg", 3'(want.drone_alarm_msg),
                                3'(i_res.drone_alarm_msg));
                    check_field("drone_clear_msg", 3'(want.drone_clear_msg),
                                3'(i_res.drone_clear_msg));
                end
            end
        end
        o_pending    <= alarm_outs_due.size();
        o_fail_cnt   <= fails;
        o_result_cnt <= results_seen;
    end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb - top level bench for two_level_thermal_alarm_fsm_top
// Drives tick requests and random result back-pressure, programs the APB
// thresholds between phases and leaves all checking to thal_alarm_checker.
// A short directed walk through every mode is followed by banded random
// episodes under several register settings and a hold with very long times.
// ----------------------------------------------------------------------------
module tb;
    import thal_pkg::*;

    localparam int IDLE_PCT    = 28;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_TICKS  = 30;

    // temperature bands relative to the current thresholds
    localparam int BAND_BELOW   = 0;
    localparam int BAND_AT_L1   = 1;
    localparam int BAND_BETWEEN = 2;
    localparam int BAND_AT_L2   = 3;
    localparam int BAND_ABOVE   = 4;
    localparam int BAND_NOISE   = 5;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic idle_on;
    int   fail_cnt;
    int   pending;
    int   result_cnt;
    int   ticks_sent   = 0;
    int   settings_cnt = 1;
    int   stall_cnt    = 0;
    int   lvl1_aim;
    int   lvl2_aim;

    thal_in_if  tick_ch ();
    thal_out_if res_ch ();

    two_level_thermal_alarm_fsm_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_out   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    thal_alarm_checker alarm_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_ch),
        .i_res        (res_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_cnt   (fail_cnt),
        .o_pending    (pending),
        .o_result_cnt (result_cnt)
    );

    // 12 unit clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // result back-pressure
    always @(posedge i_clk) begin
        res_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog: too long without any request or register access
    always @(posedge i_clk) begin
        if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("FAIL two_level_thermal_alarm_fsm_top");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    function automatic t_tick tick_of(input int temp, input int delta, input logic btn,
                                      input logic drone);
        t_tick tk;
        tk.temperature    = temp[TEMP_W-1:0];
        tk.delta_ms       = delta[DELTA_W-1:0];
        tk.button_pressed = btn;
        tk.drone_inside   = drone;
        return tk;
    endfunction

    // offer one tick, with random gaps, and hold it until taken
    task automatic push_tick(input t_tick tk);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid          <= 1'b1;
        tick_ch.temperature    <= tk.temperature;
        tick_ch.delta_ms       <= tk.delta_ms;
        tick_ch.button_pressed <= tk.button_pressed;
        tick_ch.drone_inside   <= tk.drone_inside;
        @(posedge i_clk);
        while (!tick_ch.ready)
            @(posedge i_clk);
        ticks_sent++;
    endtask

    // stop offering ticks and wait for every outstanding result
    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    task automatic apb_write(input t_ridx idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
    endtask

    // reprogram all four registers once the machine is quiet
    task automatic load_settings(input int l1, input int l2, input int pre_ms,
                                 input int alm_ms);
        drain_results();
        apb_write(REG_LEVEL1, l1);
        apb_write(REG_LEVEL2, l2);
        apb_write(REG_PREALARM, pre_ms);
        apb_write(REG_ALARM, alm_ms);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        lvl1_aim = l1;
        lvl2_aim = l2;
        settings_cnt++;
    endtask

    function automatic int pick_delta();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return 1023;
        if (r < 38)
            return 0;
        return $urandom_range(1023);
    endfunction

    function automatic int temp_in_band(input int band);
        int lo;
        int hi;
        case (band)
            BAND_BELOW: begin
                lo = lvl1_aim - 300;
                hi = lvl1_aim - 1;
            end
            BAND_AT_L1: begin
                lo = lvl1_aim;
                hi = lvl1_aim;
            end
            BAND_BETWEEN: begin
                lo = lvl1_aim + 1;
                hi = lvl2_aim - 1;
            end
            BAND_AT_L2: begin
                lo = lvl2_aim;
                hi = lvl2_aim;
            end
            BAND_ABOVE: begin
                lo = lvl2_aim + 1;
                hi = lvl2_aim + 300;
            end
            default: begin
                return $urandom_range(4095);
            end
        endcase
        if (lo < -2048) lo = -2048;
        if (lo > 2047)  lo = 2047;
        if (hi > 2047)  hi = 2047;
        if (hi < lo)    hi = lo;
        return lo + $urandom_range(hi - lo);
    endfunction

    // episodes: a band held for a run of ticks, with some plain noise
    task automatic run_random(input int n);
        int left;
        int run;
        int r;
        int band;
        left = n;
        while (left > 0) begin
            r = $urandom_range(99);
            if (r < 15)       band = BAND_BELOW;
            else if (r < 22)  band = BAND_AT_L1;
            else if (r < 50)  band = BAND_BETWEEN;
            else if (r < 57)  band = BAND_AT_L2;
            else if (r < 92)  band = BAND_ABOVE;
            else              band = BAND_NOISE;
            run = $urandom_range(14, 1);
            for (int k = 0; k < run && left > 0; k++) begin
                push_tick(tick_of(temp_in_band(band), pick_delta(),
                                  $urandom_range(99) < 20, 1'($urandom_range(1))));
                left--;
            end
        end
    endtask

    // walk through every mode with the reset thresholds (300 / 330, 5000 ms)
    task automatic run_directed();
        push_tick(tick_of(-2048, 0, 1'b0, 1'b0));    // coldest sample, idle
        push_tick(tick_of(300, 1023, 1'b1, 1'b1));   // equal to level 1, button ignored
        push_tick(tick_of(301, 1023, 1'b0, 1'b0));   // over level 1
        push_tick(tick_of(300, 1023, 1'b0, 1'b0));   // equal to level 1 does not leave
        push_tick(tick_of(330, 512, 1'b0, 1'b0));    // equal to level 2 does not enter
        push_tick(tick_of(2047, 100, 1'b0, 1'b0));   // hottest sample, into level 2
        push_tick(tick_of(330, 1023, 1'b0, 1'b0));   // equal to level 2 stays
        push_tick(tick_of(329, 0, 1'b0, 1'b0));      // back to level 1, carried time kept
        push_tick(tick_of(400, 1023, 1'b0, 1'b0));   // level 2 again
        // pre-alarm from carried time, then the alarm
        repeat (5) push_tick(tick_of(400, 1023, 1'b0, 1'b0));
        // first tick waiting for reset with the button down: both drone messages
        push_tick(tick_of(400, 1023, 1'b1, 1'b0));
        push_tick(tick_of(-550, 1023, 1'b0, 1'b0));
        push_tick(tick_of(1250, 1023, 1'b0, 1'b1));
        // pre-alarm on level 1 alone, then wait for normal
        repeat (5) push_tick(tick_of(310, 1023, 1'b0, 1'b1));
        push_tick(tick_of(-550, 0, 1'b0, 1'b1));     // back to idle, drone inside
    endtask

    // stay over level 2 with very long pre-alarm and alarm times
    task automatic run_long_hold();
        push_tick(tick_of(-2048, 1023, 1'b1, 1'b0));
        for (int k = 0; k < HOLD_TICKS; k++)
            push_tick(tick_of($urandom_range(2047), 1023, 1'b0, 1'($urandom_range(1))));
        repeat (2) push_tick(tick_of(0, 1023, 1'b1, 1'($urandom_range(1))));
    endtask

    initial begin
        i_rst_n                <= 1'b0;
        idle_on                <= 1'b1;
        tick_ch.valid          <= 1'b0;
        tick_ch.temperature    <= '0;
        tick_ch.delta_ms       <= '0;
        tick_ch.button_pressed <= 1'b0;
        tick_ch.drone_inside   <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        lvl1_aim = LEVEL1_RST;
        lvl2_aim = LEVEL2_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        load_settings(250, 280, 1500, 2500);
        run_random(200);
        // thresholds at the ends of the 12-bit range, zero times
        load_settings(-2048, 2047, 0, 0);
        run_random(100);
        // equal thresholds, alarm sooner than pre-alarm
        load_settings(150, 150, 3000, 1000);
        run_random(180);
        // level 2 below level 1
        load_settings(100, -100, 800, 16777215);
        run_random(150);
        load_settings(-550, 1250, 4000, 6000);
        run_random(120);
        // no gaps on either side for a while
        idle_on <= 1'b0;
        load_settings(0, 50, 2000, 3000);
        run_random(200);
        idle_on <= 1'b1;
        load_settings(-2048, -2048, 16777215, 16777214);
        run_long_hold();
        load_settings(2047, 2047, 16777215, 0);
        run_random(40);

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d ticks and checked %0d results over %0d register settings,",
                 ticks_sent, result_cnt, settings_cnt);
        $display("covering every mode, equal and inverted thresholds and extreme times.");
        if (fail_cnt == 0 && pending == 0) begin
            $display("PASS two_level_thermal_alarm_fsm_top");
        end else begin
            $display("FAIL two_level_thermal_alarm_fsm_top");
        end
        $finish;
    end

endmodule
